### src/mrs_pkg.sv
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared types, constants and helpers of the magnetometer read sequencer.
// ----------------------------------------------------------------------------
package mrs_pkg;

    localparam int MRS_QUEUE_DEPTH = 2;

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int GAIN_W      = 9;
    localparam int WAIT_W      = 16;

    typedef logic [2:0] t_kind;
    localparam t_kind KIND_WRITE    = 3'd0;
    localparam t_kind KIND_FETCH    = 3'd1;
    localparam t_kind KIND_SAMPLE   = 3'd2;
    localparam t_kind KIND_NONE     = 3'd3;
    localparam t_kind KIND_OVERFLOW = 3'd4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_GAIN_X  = 2'd0;
    localparam t_cfg_idx CFG_GAIN_Y  = 2'd1;
    localparam t_cfg_idx CFG_GAIN_Z  = 2'd2;
    localparam t_cfg_idx CFG_WAIT_US = 2'd3;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd256;
    localparam logic [WAIT_W-1:0] WAIT_RESET = 16'd8000;

    localparam logic [6:0] HUB_SLV_ADDR = 7'h25;
    localparam logic [6:0] HUB_SLV_REG  = 7'h26;
    localparam logic [6:0] HUB_SLV_CTRL = 7'h27;
    localparam logic [6:0] HUB_SLV_DO   = 7'h63;
    localparam logic [6:0] HUB_EXT_DATA = 7'h49;

    localparam logic [7:0] MAG_I2C_ADDR    = 8'h0C;
    localparam logic [7:0] READ_BIT        = 8'h80;
    localparam logic [7:0] SLV_ENABLE      = 8'h80;
    localparam logic [7:0] REG_ST1         = 8'h02;
    localparam logic [7:0] REG_HXL         = 8'h03;
    localparam logic [7:0] REG_CNTL1       = 8'h0A;
    localparam logic [7:0] MEASURE_ONCE_16 = 8'h11;
    localparam logic [3:0] LEN_STATUS      = 4'd1;
    localparam logic [3:0] LEN_DATA        = 4'd7;
    localparam logic [3:0] LEN_CTRL_ONE    = 4'd1;
    localparam int         ST1_READY_BIT   = 0;
    localparam int         ST2_OVF_BIT     = 3;

    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_FETCH   = 2'd1,
        OP_QUEUE   = 2'd2,
        OP_MEASURE = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  rd_reg;
        logic [3:0]  len;
        logic        ovf;
        logic [47:0] raw;
    } t_cmd;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

### src/mrs_front.sv
// ----------------------------------------------------------------------------
// mrs_front
// Accepts input transactions, tracks the read phase and issues commands.
// ----------------------------------------------------------------------------
module mrs_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_req_type,
    input  logic [mrs_pkg::IN_TDATA_W-1:0]     i_data,
    input  logic [mrs_pkg::WAIT_W-1:0]         i_wait_us,
    output logic                               o_cmd_valid,
    output mrs_pkg::t_cmd                      o_cmd,
    input  logic                               i_cmd_ready
);
    import mrs_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_STATUS = 3'b010,
        PH_DATA   = 3'b100
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_await, n_await;
    logic [31:0] r_start, n_start;
    logic [3:0]  r_pend, n_pend;

    logic        accept;
    logic [31:0] now;
    logic [31:0] diff;
    logic        wait_done;
    t_cmd        cmd;

    assign o_ready     = i_cmd_ready;
    assign accept      = i_valid && i_cmd_ready;
    assign now         = i_data[31:0];
    assign diff        = now - r_start;
    assign wait_done   = !diff[31] && (diff >= {16'd0, i_wait_us});
    assign o_cmd_valid = i_valid;
    assign o_cmd       = cmd;

    always_comb begin
        n_phase    = r_phase;
        n_await    = r_await;
        n_start    = r_start;
        n_pend     = r_pend;
        cmd.op     = OP_NONE;
        cmd.rd_reg = REG_ST1;
        cmd.len    = LEN_STATUS;
        cmd.ovf    = i_data[80 + ST2_OVF_BIT];
        cmd.raw    = i_data[79:32];
        if (!i_req_type) begin
            case (r_phase)
                PH_STATUS, PH_DATA: begin
                    if (!r_await && wait_done) begin
                        cmd.op  = OP_FETCH;
                        cmd.len = r_pend;
                        n_await = 1'b1;
                    end
                end
                default: begin
                    cmd.op  = OP_QUEUE;
                    n_pend  = LEN_STATUS;
                    n_start = now;
                    n_await = 1'b0;
                    n_phase = PH_STATUS;
                end
            endcase
        end else if (r_await) begin
            case (r_phase)
                PH_STATUS: begin
                    cmd.op  = OP_QUEUE;
                    n_start = now;
                    n_await = 1'b0;
                    if (i_data[32 + ST1_READY_BIT]) begin
                        cmd.rd_reg = REG_HXL;
                        cmd.len    = LEN_DATA;
                        n_pend     = LEN_DATA;
                        n_phase    = PH_DATA;
                    end else begin
                        n_pend  = LEN_STATUS;
                        n_phase = PH_STATUS;
                    end
                end
                PH_DATA: begin
                    cmd.op  = OP_MEASURE;
                    n_await = 1'b0;
                    n_phase = PH_IDLE;
                end
                default: begin
                    cmd.op = OP_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_await <= 1'b0;
            r_start <= '0;
            r_pend  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_await <= n_await;
            r_start <= n_start;
            r_pend  <= n_pend;
        end
    end

endmodule

### src/mrs_queue.sv
// ----------------------------------------------------------------------------
// mrs_queue
// Small command FIFO between the front and the back.
// ----------------------------------------------------------------------------
module mrs_queue #(
    parameter int DEPTH = mrs_pkg::MRS_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  mrs_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output mrs_pkg::t_cmd o_cmd
);
    import mrs_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push, pop;

    assign o_ready = (r_cnt != FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

### src/mrs_back.sv
// ----------------------------------------------------------------------------
// mrs_back
// Expands commands into result transactions and scales the sample.
// ----------------------------------------------------------------------------
module mrs_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cmd_valid,
    output logic                               o_cmd_ready,
    input  mrs_pkg::t_cmd                      i_cmd,
    input  logic [mrs_pkg::GAIN_W-1:0]         i_gain_x,
    input  logic [mrs_pkg::GAIN_W-1:0]         i_gain_y,
    input  logic [mrs_pkg::GAIN_W-1:0]         i_gain_z,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [mrs_pkg::OUT_TDATA_W-1:0]    o_data,
    output mrs_pkg::t_kind                     o_kind,
    output logic                               o_last
);
    import mrs_pkg::*;

    t_cmd        r_cmd;
    logic        r_busy;
    logic [2:0]  r_step;
    logic        r_valid;
    logic [OUT_TDATA_W-1:0] r_data;
    t_kind       r_kind;
    logic        r_last;

    logic signed [25:0] r_prod_a, r_prod_b, r_prod_c;
    logic signed [15:0] r_mag_x, r_mag_y, r_mag_z;

    logic        emit, pop;
    t_kind       res_kind;
    logic [6:0]  res_addr;
    logic [7:0]  res_wdata;
    logic [3:0]  res_len;
    logic [15:0] res_x, res_y, res_z;
    logic        res_last;

    logic signed [17:0] q_a, q_b, q_c;
    logic signed [15:0] s_c;

    assign emit        = r_busy && (!r_valid || i_ready);
    assign pop         = i_cmd_valid && (!r_busy || (emit && res_last));
    assign o_cmd_ready = pop;
    assign o_valid     = r_valid;
    assign o_data      = r_data;
    assign o_kind      = r_kind;
    assign o_last      = r_last;

    always_comb begin
        res_kind  = KIND_WRITE;
        res_addr  = '0;
        res_wdata = '0;
        res_len   = '0;
        res_x     = '0;
        res_y     = '0;
        res_z     = '0;
        res_last  = 1'b0;
        case (r_cmd.op)
            OP_NONE: begin
                res_kind = KIND_NONE;
                res_last = 1'b1;
            end
            OP_FETCH: begin
                res_kind = KIND_FETCH;
                res_addr = HUB_EXT_DATA;
                res_len  = r_cmd.len;
                res_last = 1'b1;
            end
            OP_QUEUE: begin
                case (r_step)
                    3'd0: begin
                        res_addr  = HUB_SLV_ADDR;
                        res_wdata = MAG_I2C_ADDR | READ_BIT;
                    end
                    3'd1: begin
                        res_addr  = HUB_SLV_REG;
                        res_wdata = r_cmd.rd_reg;
                    end
                    default: begin
                        res_addr  = HUB_SLV_CTRL;
                        res_wdata = {4'd0, r_cmd.len} | SLV_ENABLE;
                        res_last  = 1'b1;
                    end
                endcase
            end
            default: begin
                case (r_step)
                    3'd0: begin
                        res_addr  = HUB_SLV_ADDR;
                        res_wdata = MAG_I2C_ADDR;
                    end
                    3'd1: begin
                        res_addr  = HUB_SLV_REG;
                        res_wdata = REG_CNTL1;
                    end
                    3'd2: begin
                        res_addr  = HUB_SLV_DO;
                        res_wdata = MEASURE_ONCE_16;
                    end
                    3'd3: begin
                        res_addr  = HUB_SLV_CTRL;
                        res_wdata = {4'd0, LEN_CTRL_ONE} | SLV_ENABLE;
                    end
                    default: begin
                        res_last = 1'b1;
                        if (r_cmd.ovf) begin
                            res_kind = KIND_OVERFLOW;
                        end else begin
                            res_kind = KIND_SAMPLE;
                            res_x    = r_mag_x;
                            res_y    = r_mag_y;
                            res_z    = r_mag_z;
                        end
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (pop) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (emit && res_last) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_cmd;
        end
        if (emit) begin
            r_kind <= res_kind;
            r_last <= res_last;
            r_data <= {5'd0, res_z, res_y, res_x, res_len, res_wdata, res_addr};
        end
    end

    // scale: product, then truncate toward zero and saturate
    always_comb begin
        q_a = 18'((r_prod_a + (r_prod_a[25] ? 26'sd255 : 26'sd0)) >>> 8);
        q_b = 18'((r_prod_b + (r_prod_b[25] ? 26'sd255 : 26'sd0)) >>> 8);
        q_c = 18'((r_prod_c + (r_prod_c[25] ? 26'sd255 : 26'sd0)) >>> 8);
        s_c = sat16(q_c);
    end

    always_ff @(posedge i_clk) begin
        r_prod_a <= $signed(r_cmd.raw[15:0])  * $signed({1'b0, i_gain_x});
        r_prod_b <= $signed(r_cmd.raw[31:16]) * $signed({1'b0, i_gain_y});
        r_prod_c <= $signed(r_cmd.raw[47:32]) * $signed({1'b0, i_gain_z});
        r_mag_y  <= sat16(q_a);
        r_mag_x  <= sat16(q_b);
        r_mag_z  <= (s_c == 16'sh8000) ? 16'sh7FFF : -s_c;
    end

endmodule

### src/magnetometer_read_sequencer_core.sv
// ----------------------------------------------------------------------------
// magnetometer_read_sequencer_core
// Magnetometer read sequencer over a sensor hub acting as I2C master.
// ----------------------------------------------------------------------------
// The front takes one input transaction per cycle while the command queue has
// room; a poll or a delivery is classified at once and the read state moves
// on. The back turns each command into one, three or five result
// transactions at one per cycle while the output does not stall, and that
// result count sets the sustained rate. Axis scaling runs in two register
// stages beside the four measure-command writes, so the sample is ready when
// its turn comes. A registered output stage holds a result until it is taken,
// and the command queue lets the front keep accepting while it has room.
module magnetometer_read_sequencer_core #(
    parameter int QUEUE_DEPTH = mrs_pkg::MRS_QUEUE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // now_us[31:0], data_byte0[39:32] .. data_byte6[87:80]
    input  logic [mrs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // req_type[0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // reg_addr[6:0], reg_data[14:7], read_len[18:15], mag_x[34:19],
    // mag_y[50:35], mag_z[66:51], zero[71:67]
    output logic [mrs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // kind[2:0]
    output mrs_pkg::t_kind                     m_axis_tuser,
    output logic                               m_axis_tlast,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  mrs_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [mrs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mrs_pkg::*;

    logic [GAIN_W-1:0] r_gain_x, r_gain_y, r_gain_z;
    logic [WAIT_W-1:0] r_wait_us;

    logic f_valid, f_ready;
    t_cmd f_cmd;
    logic b_valid, b_ready;
    t_cmd b_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_x  <= GAIN_RESET;
            r_gain_y  <= GAIN_RESET;
            r_gain_z  <= GAIN_RESET;
            r_wait_us <= WAIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GAIN_X:  r_gain_x  <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_Y:  r_gain_y  <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_Z:  r_gain_z  <= i_cfg_data[GAIN_W-1:0];
                default:     r_wait_us <= i_cfg_data[WAIT_W-1:0];
            endcase
        end
    end

    mrs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_req_type  (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .i_wait_us   (r_wait_us),
        .o_cmd_valid (f_valid),
        .o_cmd       (f_cmd),
        .i_cmd_ready (f_ready)
    );

    mrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_cmd   (f_cmd),
        .o_valid (b_valid),
        .i_ready (b_ready),
        .o_cmd   (b_cmd)
    );

    mrs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (b_valid),
        .o_cmd_ready (b_ready),
        .i_cmd       (b_cmd),
        .i_gain_x    (r_gain_x),
        .i_gain_y    (r_gain_y),
        .i_gain_z    (r_gain_z),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_kind      (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

endmodule
